@@ rtl/ssdd_pkg.sv @@
package ssdd_pkg;

    localparam int MAX_ANCHORS_DEF = 2048;
    localparam int MAX_CLASSES = 128;

    localparam int PRIOR_W = 64;

    localparam logic [1:0] OP_PRIOR  = 2'd0;
    localparam logic [1:0] OP_BOX    = 2'd1;
    localparam logic [1:0] OP_CLASS  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] REG_THRESH = 3'd0;
    localparam logic [2:0] REG_RCY    = 3'd1;
    localparam logic [2:0] REG_RCX    = 3'd2;
    localparam logic [2:0] REG_RH     = 3'd3;
    localparam logic [2:0] REG_RW     = 3'd4;
    localparam logic [2:0] REG_IMGW   = 3'd5;
    localparam logic [2:0] REG_IMGH   = 3'd6;

    localparam logic [15:0] RST_THRESH = 16'd0;
    localparam logic [15:0] RST_RC     = 16'd6554;
    localparam logic [15:0] RST_RS     = 16'd13107;
    localparam logic [12:0] RST_IMG    = 13'd300;

    // log2(e) in Q1.15
    localparam logic signed [17:0] LOG2E = 18'sd47274;

    function automatic logic [17:0] pow2_frac(input logic [4:0] idx);
        logic [17:0] v;
        case (idx)
            5'd0:  v = 18'd65536;
            5'd1:  v = 18'd68438;
            5'd2:  v = 18'd71468;
            5'd3:  v = 18'd74632;
            5'd4:  v = 18'd77936;
            5'd5:  v = 18'd81386;
            5'd6:  v = 18'd84990;
            5'd7:  v = 18'd88753;
            5'd8:  v = 18'd92682;
            5'd9:  v = 18'd96785;
            5'd10: v = 18'd101070;
            5'd11: v = 18'd105545;
            5'd12: v = 18'd110218;
            5'd13: v = 18'd115098;
            5'd14: v = 18'd120194;
            5'd15: v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    // 2^(w/256) in Q16.16, w in Q.8, saturating
    function automatic logic [31:0] exp_q16(input logic signed [17:0] w);
        logic signed [9:0] ip;
        logic [3:0]  idx;
        logic [3:0]  lo;
        logic [17:0] base;
        logic [17:0] nxt;
        logic [17:0] inc;
        logic [17:0] m;
        logic [9:0]  nip;
        logic [31:0] r;
        ip   = w[17:8];
        idx  = w[7:4];
        lo   = w[3:0];
        base = pow2_frac({1'b0, idx});
        nxt  = pow2_frac({1'b0, idx} + 5'd1);
        inc  = ((nxt - base) * {14'd0, lo}) >> 4;
        m    = base + inc;
        nip  = -ip;
        if (ip >= 10'sd15) begin
            r = 32'h7FFF_FFFF;
        end else if (ip >= 10'sd0) begin
            r = {14'd0, m} << ip[3:0];
        end else if (ip <= -10'sd32) begin
            r = 32'd0;
        end else begin
            r = {14'd0, m} >> nip[4:0];
        end
        return r;
    endfunction

    // clamp a Q.30 value to [0, 2^46]
    function automatic logic signed [48:0] clamp_q(input logic signed [48:0] q);
        logic signed [48:0] r;
        if (q[48]) begin
            r = '0;
        end else if (q > (49'sd1 <<< 46)) begin
            r = 49'sd1 <<< 46;
        end else begin
            r = q;
        end
        return r;
    endfunction

    function automatic logic [15:0] to_pixel(input logic signed [66:0] p);
        logic [15:0] r;
        if (|p[58:46]) begin
            r = 16'hFFFF;
        end else begin
            r = p[45:30];
        end
        return r;
    endfunction

endpackage

@@ rtl/ssdd_ram.sv @@
module ssdd_ram #(
    parameter int WIDTH = ssdd_pkg::PRIOR_W,
    parameter int DEPTH = ssdd_pkg::MAX_ANCHORS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/ssd_anchor_box_decode.sv @@
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    operation, anchor, value_a..d, class, logit, last
// m_       out        m_valid/m_ready    anchor, class, box left/top/width/height, score
// apb      in         psel/penable       7 config registers at 4*i
//
// Prior load and plain class items leave the block idle, ready for the next item.
// Box item: a load step, then 8 steps per axis (x, then y), 7 of them on the shared 49x18 multiplier.
// Last class item with a detection: SC1, SC2, a bit-serial divide, then OUT.
// aresetn clears control and resets config to defaults; the prior table holds garbage until loaded.
// A waiting result stalls nothing until the next detection reaches OUT, which then blocks all input.
module ssd_anchor_box_decode #(
    parameter int MAX_ANCHORS = ssdd_pkg::MAX_ANCHORS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [10:0]        s_anchor_index,
    input  logic signed [15:0] s_value_a,
    input  logic signed [15:0] s_value_b,
    input  logic signed [15:0] s_value_c,
    input  logic signed [15:0] s_value_d,
    input  logic [6:0]         s_class_index,
    input  logic signed [15:0] s_class_logit,
    input  logic               s_last_class,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [10:0]        m_det_anchor,
    output logic [6:0]         m_det_class,
    output logic [15:0]        m_box_left,
    output logic [15:0]        m_box_top,
    output logic [15:0]        m_box_width,
    output logic [15:0]        m_box_height,
    output logic [15:0]        m_det_score
);

    localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOAD = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_M2   = 4'd3;
    localparam logic [3:0] ST_M3   = 4'd4;
    localparam logic [3:0] ST_M4   = 4'd5;
    localparam logic [3:0] ST_M5   = 4'd6;
    localparam logic [3:0] ST_M6   = 4'd7;
    localparam logic [3:0] ST_M7   = 4'd8;
    localparam logic [3:0] ST_M8   = 4'd9;
    localparam logic [3:0] ST_SC1  = 4'd10;
    localparam logic [3:0] ST_SC2  = 4'd11;
    localparam logic [3:0] ST_DIV  = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic signed [15:0] thr_reg;
    logic [15:0]        rcy_reg, rcx_reg, rh_reg, rw_reg;
    logic [12:0]        imgw_reg, imgh_reg;

    logic               ax_reg;
    logic               inr_reg;
    logic [63:0]        dlt_reg;
    logic [63:0]        prior_reg;
    logic signed [66:0] p_reg;
    logic signed [48:0] c30_reg;
    logic signed [47:0] s30_reg;
    logic [15:0]        left_reg, top_reg, width_reg, height_reg;

    logic signed [15:0] best_logit_reg;
    logic [6:0]         best_class_reg;
    logic               found_reg;
    logic [10:0]        res_anchor_reg;
    logic [6:0]         res_class_reg;
    logic signed [15:0] res_logit_reg;

    logic [32:0]        div_r_reg;
    logic [47:0]        div_d_reg;
    logic [16:0]        div_q_reg;
    logic [4:0]         div_cnt_reg;

    logic               m_valid_reg;
    logic [10:0]        m_anchor_reg;
    logic [6:0]         m_class_reg;
    logic [15:0]        m_left_reg, m_top_reg, m_width_reg, m_height_reg, m_score_reg;

    logic               s_xfer, cfg_wr, in_range;
    logic [AW-1:0]      ram_addr;
    logic [63:0]        ram_rdata;

    logic signed [15:0] dc, ds, pc, psz;
    logic [15:0]        rc, rs;
    logic [12:0]        img;
    logic signed [48:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [66:0] mul_p;
    logic signed [16:0] t_val;
    logic signed [17:0] w_val;
    logic [31:0]        e_val;
    logic signed [48:0] c30_val;
    logic signed [48:0] q_val;
    logic signed [16:0] neg_logit;
    logic [31:0]        den;
    logic               cls_ok, cls_upd, found_eff;
    logic [6:0]         class_eff;
    logic signed [15:0] logit_eff;
    logic               div_ge;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign in_range = {21'd0, s_anchor_index} < MAX_ANCHORS;
    assign ram_addr = AW'(s_anchor_index);

    ssdd_ram #(
        .WIDTH (ssdd_pkg::PRIOR_W),
        .DEPTH (MAX_ANCHORS),
        .AW    (AW)
    ) u_prior (
        .aclk  (aclk),
        .we    (s_xfer && s_operation == ssdd_pkg::OP_PRIOR && in_range),
        .waddr (ram_addr),
        .wdata ({s_value_a, s_value_b, s_value_c, s_value_d}),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        unique case (paddr[4:2])
            ssdd_pkg::REG_THRESH: prdata = {16'd0, thr_reg};
            ssdd_pkg::REG_RCY:    prdata = {16'd0, rcy_reg};
            ssdd_pkg::REG_RCX:    prdata = {16'd0, rcx_reg};
            ssdd_pkg::REG_RH:     prdata = {16'd0, rh_reg};
            ssdd_pkg::REG_RW:     prdata = {16'd0, rw_reg};
            ssdd_pkg::REG_IMGW:   prdata = {19'd0, imgw_reg};
            ssdd_pkg::REG_IMGH:   prdata = {19'd0, imgh_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // axis operand select: 0 = x, 1 = y
    assign dc  = ax_reg ? dlt_reg[63:48]   : dlt_reg[47:32];
    assign ds  = ax_reg ? dlt_reg[31:16]   : dlt_reg[15:0];
    assign pc  = ax_reg ? prior_reg[63:48] : prior_reg[47:32];
    assign psz = ax_reg ? prior_reg[31:16] : prior_reg[15:0];
    assign rc  = ax_reg ? rcy_reg  : rcx_reg;
    assign rs  = ax_reg ? rh_reg   : rw_reg;
    assign img = ax_reg ? imgh_reg : imgw_reg;

    assign t_val     = p_reg[32:16];
    assign w_val     = p_reg[32:15];
    assign e_val     = ssdd_pkg::exp_q16(w_val);
    assign c30_val   = 49'($signed(p_reg[47:8])) + {{17{pc[15]}}, pc, 16'd0};
    assign q_val     = c30_reg - 49'($signed(p_reg[47:1]));
    assign neg_logit = -{res_logit_reg[15], res_logit_reg};
    assign den       = 32'h0001_0000 + e_val;
    assign div_ge    = {15'd0, div_r_reg} >= div_d_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_M1: begin
                mul_a = 49'(dc);
                mul_b = {2'b00, rc};
            end
            ST_M2: begin
                mul_a = 49'($signed(p_reg[32:0]));
                mul_b = 18'(psz);
            end
            ST_M3: begin
                mul_a = 49'(ds);
                mul_b = {2'b00, rs};
            end
            ST_M4: begin
                mul_a = 49'(t_val);
                mul_b = ssdd_pkg::LOG2E;
            end
            ST_M5: begin
                mul_a = {17'd0, e_val};
                mul_b = 18'(psz);
            end
            ST_M6: begin
                mul_a = ssdd_pkg::clamp_q(q_val);
                mul_b = {5'd0, img};
            end
            ST_M7: begin
                mul_a = ssdd_pkg::clamp_q(49'(s30_reg));
                mul_b = {5'd0, img};
            end
            ST_SC1: begin
                mul_a = 49'(neg_logit);
                mul_b = ssdd_pkg::LOG2E;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign cls_ok = s_class_index != 7'd0
                 && {25'd0, s_class_index} < ssdd_pkg::MAX_CLASSES
                 && s_class_logit >= thr_reg;
    assign cls_upd   = cls_ok && (!found_reg || s_class_logit > best_logit_reg);
    assign found_eff = found_reg || cls_ok;
    assign class_eff = cls_upd ? s_class_index : best_class_reg;
    assign logit_eff = cls_upd ? s_class_logit : best_logit_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && s_operation == ssdd_pkg::OP_BOX) begin
                    state_next = ST_LOAD;
                end else if (s_xfer && s_operation == ssdd_pkg::OP_CLASS
                             && s_last_class && found_eff) begin
                    state_next = ST_SC1;
                end
            end
            ST_LOAD: state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_M5;
            ST_M5:   state_next = ST_M6;
            ST_M6:   state_next = ST_M7;
            ST_M7:   state_next = ST_M8;
            ST_M8:   state_next = ax_reg ? ST_IDLE : ST_M1;
            ST_SC1:  state_next = ST_SC2;
            ST_SC2:  state_next = ST_DIV;
            ST_DIV:  state_next = (div_cnt_reg == 5'd0) ? ST_OUT : ST_DIV;
            ST_OUT:  state_next = (!m_valid_reg || m_ready) ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        p_reg <= mul_p;
        if (s_xfer) begin
            dlt_reg        <= {s_value_a, s_value_b, s_value_c, s_value_d};
            inr_reg        <= in_range;
            res_anchor_reg <= s_anchor_index;
            res_class_reg  <= class_eff;
            res_logit_reg  <= logit_eff;
        end
        case (state_reg)
            ST_LOAD: prior_reg <= inr_reg ? ram_rdata : 64'd0;
            ST_M3:   c30_reg   <= c30_val;
            ST_M6:   s30_reg   <= p_reg[47:0];
            ST_M8: begin
                if (ax_reg) begin
                    height_reg <= ssdd_pkg::to_pixel(p_reg);
                end else begin
                    width_reg <= ssdd_pkg::to_pixel(p_reg);
                end
            end
            ST_SC2: begin
                div_r_reg <= 33'h1_0000_0000;
                div_d_reg <= {den, 16'd0};
                div_q_reg <= '0;
            end
            ST_DIV: begin
                if (div_ge) begin
                    div_r_reg <= div_r_reg - div_d_reg[32:0];
                end
                div_d_reg <= div_d_reg >> 1;
                div_q_reg <= {div_q_reg[15:0], div_ge};
            end
            default: ;
        endcase
        if (state_reg == ST_M7) begin
            if (ax_reg) begin
                top_reg <= ssdd_pkg::to_pixel(p_reg);
            end else begin
                left_reg <= ssdd_pkg::to_pixel(p_reg);
            end
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_anchor_reg <= res_anchor_reg;
            m_class_reg  <= res_class_reg;
            m_left_reg   <= left_reg;
            m_top_reg    <= top_reg;
            m_width_reg  <= width_reg;
            m_height_reg <= height_reg;
            m_score_reg  <= div_q_reg[16] ? 16'hFFFF : div_q_reg[15:0];
        end

        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ax_reg         <= 1'b0;
            div_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            best_class_reg <= '0;
            best_logit_reg <= '0;
            left_reg       <= '0;
            top_reg        <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            thr_reg        <= ssdd_pkg::RST_THRESH;
            rcy_reg        <= ssdd_pkg::RST_RC;
            rcx_reg        <= ssdd_pkg::RST_RC;
            rh_reg         <= ssdd_pkg::RST_RS;
            rw_reg         <= ssdd_pkg::RST_RS;
            imgw_reg       <= ssdd_pkg::RST_IMG;
            imgh_reg       <= ssdd_pkg::RST_IMG;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_LOAD) begin
                ax_reg <= 1'b0;
            end else if (state_reg == ST_M8) begin
                ax_reg <= ~ax_reg;
            end
            if (state_reg == ST_SC2) begin
                div_cnt_reg <= 5'd16;
            end else if (state_reg == ST_DIV) begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_xfer && s_operation == ssdd_pkg::OP_CLASS) begin
                if (s_last_class) begin
                    found_reg      <= 1'b0;
                    best_class_reg <= '0;
                    best_logit_reg <= '0;
                end else begin
                    found_reg      <= found_eff;
                    best_class_reg <= class_eff;
                    best_logit_reg <= logit_eff;
                end
            end
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    ssdd_pkg::REG_THRESH: thr_reg  <= pwdata[15:0];
                    ssdd_pkg::REG_RCY:    rcy_reg  <= pwdata[15:0];
                    ssdd_pkg::REG_RCX:    rcx_reg  <= pwdata[15:0];
                    ssdd_pkg::REG_RH:     rh_reg   <= pwdata[15:0];
                    ssdd_pkg::REG_RW:     rw_reg   <= pwdata[15:0];
                    ssdd_pkg::REG_IMGW:   imgw_reg <= pwdata[12:0];
                    ssdd_pkg::REG_IMGH:   imgh_reg <= pwdata[12:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_det_anchor = m_anchor_reg;
    assign m_det_class  = m_class_reg;
    assign m_box_left   = m_left_reg;
    assign m_box_top    = m_top_reg;
    assign m_box_width  = m_width_reg;
    assign m_box_height = m_height_reg;
    assign m_det_score  = m_score_reg;

    a_no_class_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !found_reg |-> best_class_reg == 7'd0)
        else $error("best class set without a qualifying class");

    a_found_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> best_class_reg != 7'd0)
        else $error("class zero taken as best");

    a_box_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_operation == ssdd_pkg::OP_BOX) |=> state_reg == ST_LOAD)
        else $error("box transfer did not start decode");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_cnt_reg == 5'd0) |=> state_reg == ST_OUT)
        else $error("divider did not finish");

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !s_ready)
        else $error("input taken during score divide");

endmodule

@@ dv/ssd_anchor_box_decode_test.sv @@
`timescale 1ns / 1ps

module ssd_anchor_box_decode_test;

    localparam int NUM_ANCHORS = 2048;
    localparam int CLASS_LIMIT = 128;

    typedef struct packed {
        logic [10:0] anchor;
        logic [6:0]  cls;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] score;
    } detection_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation = '0;
    logic [10:0]        s_anchor_index = '0;
    logic signed [15:0] s_value_a = '0;
    logic signed [15:0] s_value_b = '0;
    logic signed [15:0] s_value_c = '0;
    logic signed [15:0] s_value_d = '0;
    logic [6:0]         s_class_index = '0;
    logic signed [15:0] s_class_logit = '0;
    logic               s_last_class = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [10:0] m_det_anchor;
    logic [6:0]  m_det_class;
    logic [15:0] m_box_left;
    logic [15:0] m_box_top;
    logic [15:0] m_box_width;
    logic [15:0] m_box_height;
    logic [15:0] m_det_score;

    ssd_anchor_box_decode DUT (.*);

    always #10 aclk = ~aclk;

    // predictor state
    logic signed [15:0] prior_cy [NUM_ANCHORS];
    logic signed [15:0] prior_cx [NUM_ANCHORS];
    logic signed [15:0] prior_h  [NUM_ANCHORS];
    logic signed [15:0] prior_w  [NUM_ANCHORS];
    bit                 prior_loaded [NUM_ANCHORS];
    logic [15:0] box_q [4];
    longint      top_logit;
    int          top_class;
    bit          have_class;
    logic [15:0] thresh_r, rcy_r, rcx_r, rh_r, rw_r;
    logic [12:0] imgw_r, imgh_r;

    detection_t pending_dets[$];
    int errors = 0;
    int det_count = 0;
    int items_sent = 0;
    bit idle_off = 1'b0;
    bit hold_sink = 1'b0;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint exp_fix(longint u);
        longint w, ip, m;
        int f, idx, lo;
        longint tbl [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88753,
            92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
        w = fshr(u * 47274, 15);
        ip = fshr(w, 8);
        f = int'(w - ip * 256) & 255;
        idx = f >> 4;
        lo = f & 15;
        m = tbl[idx] + (((tbl[idx + 1] - tbl[idx]) * lo) >> 4);
        if (ip >= 15) return 64'h7FFF_FFFF;
        if (ip >= 0) return m << ip;
        if (-ip >= 32) return 0;
        return m >> (-ip);
    endfunction

    function automatic logic [15:0] pixel_of(longint q30, longint img);
        longint p;
        p = fshr(q30 * img, 30);
        if (p < 0) return 16'd0;
        if (p > 65535) return 16'hFFFF;
        return p[15:0];
    endfunction

    task automatic decode_axis(input longint dc, input longint ds, input longint rc,
                               input longint rs, input longint pc, input longint psz,
                               input longint img, output logic [15:0] corner,
                               output logic [15:0] size);
        longint c30, t, s30;
        c30 = fshr(dc * rc * psz, 8) + pc * 65536;
        t = fshr(ds * rs, 16);
        s30 = exp_fix(t) * psz;
        corner = pixel_of(c30 - fshr(s30, 1), img);
        size = pixel_of(s30, img);
    endtask

    task automatic predict_item(input logic [1:0] op, input logic [10:0] anc,
                                input logic signed [15:0] a, input logic signed [15:0] b,
                                input logic signed [15:0] c, input logic signed [15:0] d,
                                input logic [6:0] cls, input logic signed [15:0] lg,
                                input logic last);
        longint den, sc;
        detection_t det;
        if (op == ssdd_pkg::OP_PRIOR) begin
            prior_cy[anc] = a;
            prior_cx[anc] = b;
            prior_h[anc] = c;
            prior_w[anc] = d;
            prior_loaded[anc] = 1'b1;
        end else if (op == ssdd_pkg::OP_BOX) begin
            decode_axis(b, d, rcx_r, rw_r, prior_cx[anc], prior_w[anc], imgw_r,
                        box_q[0], box_q[2]);
            decode_axis(a, c, rcy_r, rh_r, prior_cy[anc], prior_h[anc], imgh_r,
                        box_q[1], box_q[3]);
        end else if (op == ssdd_pkg::OP_CLASS) begin
            if (cls != 0 && cls < CLASS_LIMIT && lg >= $signed(thresh_r)) begin
                if (!have_class || lg > top_logit) begin
                    top_logit = lg;
                    top_class = cls;
                    have_class = 1'b1;
                end
            end
            if (last) begin
                if (have_class) begin
                    den = 65536 + exp_fix(-top_logit);
                    sc = 64'h1_0000_0000 / den;
                    if (sc > 65535) sc = 65535;
                    det.anchor = anc;
                    det.cls = top_class[6:0];
                    det.left = box_q[0];
                    det.top = box_q[1];
                    det.width = box_q[2];
                    det.height = box_q[3];
                    det.score = sc[15:0];
                    pending_dets.push_back(det);
                end
                top_logit = 0;
                top_class = 0;
                have_class = 1'b0;
            end
        end
    endtask

    function automatic bit idle_now();
        return !idle_off && ($urandom_range(99) < 26);
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [10:0] anc,
                             input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic signed [15:0] c, input logic signed [15:0] d,
                             input logic [6:0] cls, input logic signed [15:0] lg,
                             input logic last);
        if (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (idle_now()) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_anchor_index <= anc;
        s_value_a <= a;
        s_value_b <= b;
        s_value_c <= c;
        s_value_d <= d;
        s_class_index <= cls;
        s_class_logit <= lg;
        s_last_class <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(op, anc, a, b, c, d, cls, lg, last);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ssdd_pkg::REG_THRESH: thresh_r = val[15:0];
            ssdd_pkg::REG_RCY:    rcy_r = val[15:0];
            ssdd_pkg::REG_RCX:    rcx_r = val[15:0];
            ssdd_pkg::REG_RH:     rh_r = val[15:0];
            ssdd_pkg::REG_RW:     rw_r = val[15:0];
            ssdd_pkg::REG_IMGW:   imgw_r = val[12:0];
            default:              imgh_r = val[12:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_dets.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    // a prior with random centre and size values
    task automatic load_prior(input logic [10:0] anc);
        send_item(ssdd_pkg::OP_PRIOR, anc, rnd16(), rnd16(), rnd16(), rnd16(), 7'd0,
                  16'sd0, 1'($urandom_range(1)));
    endtask

    task automatic anchor_sequence(input logic [10:0] anc, input int nclass);
        logic [6:0] cls;
        send_item(ssdd_pkg::OP_BOX, anc, rnd16(), rnd16(), rnd16(), rnd16(), 7'($urandom),
                  rnd16(), 1'($urandom_range(1)));
        for (int k = 0; k < nclass; k++) begin
            cls = ($urandom_range(9) == 0) ? 7'($urandom) : 7'(k + 1);
            send_item(ssdd_pkg::OP_CLASS, anc, rnd16(), rnd16(), rnd16(), rnd16(), cls,
                      ($urandom_range(3) == 0) ? rnd16() : 16'($signed($urandom_range(2048)) - 512),
                      k == nclass - 1);
        end
    endtask

    task automatic test_directed();
        logic signed [15:0] ext [4] = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'shFFFF};
        for (int i = 0; i < 4; i++)
            send_item(ssdd_pkg::OP_PRIOR, 11'(i), ext[i], ext[(i + 1) % 4],
                      ext[(i + 2) % 4], ext[(i + 3) % 4], 7'h7F, 16'sh7FFF, 1'b1);
        send_item(ssdd_pkg::OP_PRIOR, 11'h7FF, 16'sh2000, 16'sh2000, 16'sh1000, 16'sh1000,
                  7'd0, 16'sd0, 1'b0);
        for (int i = 0; i < 4; i++) begin
            send_item(ssdd_pkg::OP_BOX, 11'(i), ext[i], ext[3 - i], ext[(i + 2) % 4], ext[i],
                      7'd0, 16'sd0, 1'b1);
            send_item(ssdd_pkg::OP_CLASS, 11'(i), 16'sd0, 16'sd0, 16'sd0, 16'sd0, 7'd0,
                      16'sh7FFF, 1'b0);
            send_item(ssdd_pkg::OP_CLASS, 11'(i), 16'sd0, 16'sd0, 16'sd0, 16'sd0, 7'd1,
                      ext[i], 1'b0);
            send_item(ssdd_pkg::OP_CLASS, 11'(i), 16'sd0, 16'sd0, 16'sd0, 16'sd0, 7'h7F,
                      ext[i], 1'b1);
        end
        // unused op, lone class-0 end, tie on logits
        send_item(ssdd_pkg::OP_UNUSED, 11'h7FF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                  7'h7F, 16'sh7FFF, 1'b1);
        send_item(ssdd_pkg::OP_CLASS, 11'h7FF, '0, '0, '0, '0, 7'd0, 16'sh7FFF, 1'b1);
        send_item(ssdd_pkg::OP_CLASS, 11'h7FF, '0, '0, '0, '0, 7'd5, 16'sd300, 1'b0);
        send_item(ssdd_pkg::OP_CLASS, 11'h7FF, '0, '0, '0, '0, 7'd9, 16'sd300, 1'b1);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(ssdd_pkg::REG_THRESH, 32'h0000_8000);
        write_reg(ssdd_pkg::REG_RCY, 32'h0000_FFFF);
        write_reg(ssdd_pkg::REG_RCX, 32'h0);
        write_reg(ssdd_pkg::REG_RH, 32'h0000_FFFF);
        write_reg(ssdd_pkg::REG_RW, 32'h0);
        write_reg(ssdd_pkg::REG_IMGW, 32'd4096);
        write_reg(ssdd_pkg::REG_IMGH, 32'd1);
        for (int i = 0; i < 20; i++) anchor_sequence(11'($urandom_range(3)), 3);
        drain();
        write_reg(ssdd_pkg::REG_THRESH, 32'h0000_7FFF);
        write_reg(ssdd_pkg::REG_RCY, 32'h0);
        write_reg(ssdd_pkg::REG_RCX, 32'h0000_FFFF);
        write_reg(ssdd_pkg::REG_RH, 32'h0);
        write_reg(ssdd_pkg::REG_RW, 32'h0000_FFFF);
        write_reg(ssdd_pkg::REG_IMGW, 32'd1);
        write_reg(ssdd_pkg::REG_IMGH, 32'd4096);
        for (int i = 0; i < 20; i++) anchor_sequence(11'($urandom_range(3)), 3);
        drain();
    endtask

    task automatic test_random(input int count);
        logic [10:0] anc;
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(9) == 0) begin
                anc = 11'($urandom_range(NUM_ANCHORS - 1));
                load_prior(anc);
            end else begin
                do anc = 11'($urandom_range(NUM_ANCHORS - 1));
                while (!prior_loaded[anc]);
                anchor_sequence(anc, $urandom_range(1, 6));
            end
        end
    endtask

    task automatic test_backpressure();
        hold_sink = 1'b1;
        for (int i = 0; i < 30; i++) anchor_sequence(11'($urandom_range(3)), 2);
        drain();
        wait (!hold_sink);
    endtask

    // receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_sink) begin
            m_ready <= 1'b0;
            repeat (400) @(posedge aclk);
            hold_sink = 1'b0;
        end else begin
            m_ready <= !idle_now();
        end
    end

    always @(posedge aclk) begin
        detection_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_det_anchor, m_det_class, m_box_left, m_box_top, m_box_width,
                    m_box_height, m_det_score};
            if (pending_dets.size() == 0) begin
                $display("%0t: unexpected detection %p", $time, got);
                errors++;
            end else begin
                want = pending_dets.pop_front();
                det_count++;
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        #300ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        thresh_r = ssdd_pkg::RST_THRESH;
        rcy_r = ssdd_pkg::RST_RC;
        rcx_r = ssdd_pkg::RST_RC;
        rh_r = ssdd_pkg::RST_RS;
        rw_r = ssdd_pkg::RST_RS;
        imgw_r = ssdd_pkg::RST_IMG;
        imgh_r = ssdd_pkg::RST_IMG;
        top_logit = 0;
        top_class = 0;
        have_class = 1'b0;
        foreach (box_q[j]) box_q[j] = '0;
        foreach (prior_loaded[j]) prior_loaded[j] = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(500);
        drain();
        test_config_extremes();
        write_reg(ssdd_pkg::REG_THRESH, 32'h0000_FF00);
        write_reg(ssdd_pkg::REG_IMGW, 32'd640);
        write_reg(ssdd_pkg::REG_IMGH, 32'd480);
        test_backpressure();
        idle_off = 1'b1;
        test_random(300);
        idle_off = 1'b0;
        test_random(500);
        drain();
        $display("Covered %0d transfers in, %0d detections checked, over several",
                 items_sent, det_count);
        $display("register settings, back-pressure and idle-free stretches.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
